// File: rtl/avld_pkg.sv
// package for the attribute video line decoder: constants, codes and shared types
`default_nettype none
package avld_pkg;

	localparam int STORE_DEPTH = 8192;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_RENDER = 2'd1;
	localparam logic [1:0] FUNC_FRAME  = 2'd2;

	localparam logic [31:0] DIM_MASK  = 32'hFFD7D7D7;
	localparam logic [12:0] ATTR_BASE = 13'h1800;

	localparam logic [7:0] PIC_TOP    = 8'd32;
	localparam logic [7:0] PIC_BOTTOM = 8'd224;
	localparam logic [5:0] PIC_LEFT   = 6'd4;
	localparam logic [5:0] PIC_RIGHT  = 6'd36;

	localparam logic [31:0] PALETTE [8] = '{
		32'hFF000000, 32'hFFFF0000, 32'hFF0000FF, 32'hFFFF00FF,
		32'hFF00FF00, 32'hFFFFFF00, 32'hFF00FFFF, 32'hFFFFFFFF
	};

	typedef struct packed {
		logic                wr_en;
		logic [STORE_AW-1:0] wr_addr;
		logic [7:0]          wr_data;
		logic                rd_en;
		logic [STORE_AW-1:0] pix_addr;
		logic [STORE_AW-1:0] attr_addr;
	} store_req_t;

endpackage
`default_nettype wire

// File: rtl/avld_in_if.sv
// command channel: write, render and end-of-frame items
`default_nettype none
interface avld_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [12:0] addr;
	logic [7:0]  data;
	logic [7:0]  line;
	logic [5:0]  column;
	logic [2:0]  border;

	modport source (output valid, func, addr, data, line, column, border, input ready);
	modport sink (input valid, func, addr, data, line, column, border, output ready);
endinterface
`default_nettype wire

// File: rtl/avld_out_if.sv
// pixel channel: one rgba pixel per transfer
`default_nettype none
interface avld_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] rgba;
	logic        last;

	modport source (output valid, rgba, last, input ready);
	modport sink (input valid, rgba, last, output ready);
endinterface
`default_nettype wire

// File: rtl/avld_store.sv
// video byte store with clearing sweep after reset and two registered read ports
`default_nettype none
module avld_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire avld_pkg::store_req_t          req,
	output logic [7:0]                         pix_data,
	output logic [7:0]                         attr_data,
	output logic                               busy
);
	import avld_pkg::*;

	logic [7:0]          mem [STORE_DEPTH];
	logic [STORE_AW-1:0] clr_cnt_q;
	logic                clr_q;
	logic                we;
	logic [STORE_AW-1:0] wa;
	logic [7:0]          wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == STORE_AW'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_q) begin
			we = 1'b1;
			wa = clr_cnt_q;
			wd = 8'd0;
		end else begin
			we = req.wr_en;
			wa = req.wr_addr;
			wd = req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			pix_data  <= mem[req.pix_addr];
			attr_data <= mem[req.attr_addr];
		end
	end

	assign busy = clr_q;

endmodule
`default_nettype wire

// File: rtl/attribute_video_line_decoder_unit.sv
// top level: attribute video line decoder, store plus cell decode and pixel serializer
//
//   channel  dir  type         payload
//   cmd      in   avld_in_if   func addr data line column border
//   pixel    out  avld_out_if  rgba last
//
// write and frame items take effect at their transfer; a render cell gives
// eight pixels, one per cycle while pixel is ready
// the store read is registered (stage 1), colors load the pixel serializer
// after reset all 8192 store bytes (STORE_DEPTH) are zeroed, cmd not ready
// one render waits in stage 1 while the serializer drains; stalls on pixel hold it
`default_nettype none
module attribute_video_line_decoder_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	avld_in_if.sink    cmd,
	avld_out_if.source pixel
);
	import avld_pkg::*;

	store_req_t  req;
	logic [7:0]  pix_data;
	logic [7:0]  attr_data;
	logic        store_busy;

	logic        cmd_xfer;
	logic        pix_xfer;
	logic        picture;
	logic [7:0]  yy;
	logic [4:0]  x;
	logic [12:0] pix_addr;
	logic [12:0] attr_addr;

	logic [4:0]  blink_q;
	logic        valid_s1;
	logic        pic_s1;
	logic [2:0]  border_s1;
	logic        blink_s1;

	logic        ser_busy_q;
	logic [2:0]  ser_cnt_q;
	logic [31:0] ink_q;
	logic [31:0] paper_q;
	logic [7:0]  pix_q;
	logic        ser_free;
	logic        s1_adv;

	logic [31:0] ink;
	logic [31:0] paper;
	logic [7:0]  pix;
	logic [2:0]  ink_idx;
	logic [2:0]  paper_idx;

	avld_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pix_data  (pix_data),
		.attr_data (attr_data),
		.busy      (store_busy)
	);

	assign ser_free  = !ser_busy_q || (pix_xfer && ser_cnt_q == 3'd7);
	assign s1_adv    = valid_s1 && ser_free;
	assign cmd.ready = !store_busy && (!valid_s1 || ser_free);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign pix_xfer  = pixel.valid && pixel.ready;

	// picture area, address decode and store request
	always_comb begin
		picture   = cmd.line >= PIC_TOP && cmd.line < PIC_BOTTOM &&
			cmd.column >= PIC_LEFT && cmd.column < PIC_RIGHT;
		yy        = cmd.line - PIC_TOP;
		x         = 5'(cmd.column - PIC_LEFT);
		pix_addr  = {yy[7:6], yy[2:0], yy[5:3], x};
		attr_addr = ATTR_BASE + {3'd0, yy[7:3], x};

		req.wr_en     = cmd_xfer && cmd.func == FUNC_WRITE &&
			32'(cmd.addr) < 32'(STORE_DEPTH);
		req.wr_addr   = STORE_AW'(cmd.addr);
		req.wr_data   = cmd.data;
		req.rd_en     = cmd_xfer && cmd.func == FUNC_RENDER && picture;
		req.pix_addr  = STORE_AW'(pix_addr);
		req.attr_addr = STORE_AW'(attr_addr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q <= '0;
		end else if (cmd_xfer && cmd.func == FUNC_FRAME) begin
			blink_q <= blink_q + 1'b1;
		end
	end

	// stage 1: render waiting on store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_xfer && cmd.func == FUNC_RENDER) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer && cmd.func == FUNC_RENDER) begin
			pic_s1    <= picture;
			border_s1 <= cmd.border;
			blink_s1  <= blink_q[4];
		end
	end

	// cell colors
	always_comb begin
		if (attr_data[7] && blink_s1) begin
			ink_idx   = attr_data[5:3];
			paper_idx = attr_data[2:0];
		end else begin
			ink_idx   = attr_data[2:0];
			paper_idx = attr_data[5:3];
		end
		if (pic_s1) begin
			ink   = PALETTE[ink_idx];
			paper = PALETTE[paper_idx];
			if (!attr_data[6]) begin
				ink   = ink & DIM_MASK;
				paper = paper & DIM_MASK;
			end
			pix = pix_data;
		end else begin
			ink   = PALETTE[border_s1] & DIM_MASK;
			paper = ink;
			pix   = 8'd0;
		end
	end

	// pixel serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_busy_q <= 1'b0;
			ser_cnt_q  <= '0;
		end else if (s1_adv) begin
			ser_busy_q <= 1'b1;
			ser_cnt_q  <= '0;
		end else if (pix_xfer) begin
			ser_cnt_q <= ser_cnt_q + 1'b1;
			if (ser_cnt_q == 3'd7) begin
				ser_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ink_q   <= ink;
			paper_q <= paper;
			pix_q   <= pix;
		end else if (pix_xfer) begin
			pix_q <= {pix_q[6:0], 1'b0};
		end
	end

	assign pixel.valid = ser_busy_q;
	assign pixel.rgba  = pix_q[7] ? ink_q : paper_q;
	assign pixel.last  = ser_cnt_q == 3'd7;

	a_no_cmd_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> !cmd.ready)
		else $error("command taken during store clear");

	a_cell_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_xfer && !pixel.last) |=> pixel.valid)
		else $error("cell ended before its eighth pixel");

	a_blink_only_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_xfer && cmd.func == FUNC_FRAME) |=> $stable(blink_q))
		else $error("blink counter moved without a frame item");

	a_render_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> (ser_busy_q && ser_cnt_q == 3'd0))
		else $error("render did not load the serializer");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench for the attribute video line decoder: directed and random cells checked by a predictor
module testbench;
	import avld_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [12:0] addr;
		logic [7:0]  data;
		logic [7:0]  line;
		logic [5:0]  column;
		logic [2:0]  border;
	} cmd_t;

	typedef struct packed {
		logic [31:0] rgba;
		logic        last;
	} pixel_t;

	logic clk;
	logic arst_n;

	avld_in_if  cmd_ch ();
	avld_out_if pixel_ch ();

	attribute_video_line_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pixel  (pixel_ch)
	);

	logic [7:0] video_mem [STORE_DEPTH];
	logic [4:0] blink_ctr;
	pixel_t     pending_pixels [$];
	int         mismatches;
	int         send_idle_pct;
	int         stall_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 500_000);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [12:0] cell_pixel_addr(input logic [7:0] ln, input logic [5:0] col);
		logic [7:0] yy;
		logic [5:0] x;
		yy = ln - PIC_TOP;
		x = col - PIC_LEFT;
		return {yy[7:6], yy[2:0], yy[5:3], x[4:0]};
	endfunction

	function automatic logic [12:0] cell_attr_addr(input logic [7:0] ln, input logic [5:0] col);
		logic [7:0] yy;
		logic [5:0] x;
		yy = ln - PIC_TOP;
		x = col - PIC_LEFT;
		return ATTR_BASE + {3'b000, yy[7:3], x[4:0]};
	endfunction

	// updates the shadow store and blink counter, queues the eight pixels of a render
	function automatic void predict_pixels(input cmd_t c);
		logic [7:0]  attr;
		logic [7:0]  bits;
		logic [31:0] ink;
		logic [31:0] paper;
		pixel_t      px;
		case (c.func)
			FUNC_WRITE: video_mem[c.addr] = c.data;
			FUNC_FRAME: blink_ctr = blink_ctr + 5'd1;
			FUNC_RENDER: begin
				if (c.line < PIC_TOP || c.line >= PIC_BOTTOM ||
						c.column < PIC_LEFT || c.column >= PIC_RIGHT) begin
					ink = PALETTE[c.border] & DIM_MASK;
					paper = ink;
					bits = 8'h00;
				end else begin
					attr = video_mem[cell_attr_addr(c.line, c.column)];
					bits = video_mem[cell_pixel_addr(c.line, c.column)];
					if (attr[7] && blink_ctr[4]) begin
						ink = PALETTE[attr[5:3]];
						paper = PALETTE[attr[2:0]];
					end else begin
						ink = PALETTE[attr[2:0]];
						paper = PALETTE[attr[5:3]];
					end
					if (!attr[6]) begin
						ink = ink & DIM_MASK;
						paper = paper & DIM_MASK;
					end
				end
				for (int k = 0; k < 8; k++) begin
					px.rgba = bits[7 - k] ? ink : paper;
					px.last = (k == 7);
					pending_pixels.push_back(px);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.func = 2'($urandom_range(3));
		c.addr = 13'($urandom_range(8191));
		c.data = 8'($urandom_range(255));
		c.line = 8'($urandom_range(255));
		c.column = 6'($urandom_range(63));
		c.border = 3'($urandom_range(7));
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c);
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= c.func;
		cmd_ch.addr <= c.addr;
		cmd_ch.data <= c.data;
		cmd_ch.line <= c.line;
		cmd_ch.column <= c.column;
		cmd_ch.border <= c.border;
		do @(posedge clk); while (!cmd_ch.ready);
		predict_pixels(c);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic write_byte(input logic [12:0] a, input logic [7:0] d);
		cmd_t c;
		c = random_cmd();
		c.func = FUNC_WRITE;
		c.addr = a;
		c.data = d;
		send_cmd(c);
	endtask

	task automatic render_cell(input logic [7:0] ln, input logic [5:0] col, input logic [2:0] b);
		cmd_t c;
		c = random_cmd();
		c.func = FUNC_RENDER;
		c.line = ln;
		c.column = col;
		c.border = b;
		send_cmd(c);
	endtask

	task automatic end_frame();
		cmd_t c;
		c = random_cmd();
		c.func = FUNC_FRAME;
		send_cmd(c);
	endtask

	task automatic wait_for_pixels();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	task automatic test_border_cells();
		render_cell(8'd0, 6'd0, 3'd0);
		render_cell(8'd31, 6'd20, 3'd7);
		render_cell(8'd224, 6'd20, 3'd1);
		render_cell(8'd255, 6'd39, 3'd2);
		render_cell(8'd100, 6'd3, 3'd3);
		render_cell(8'd100, 6'd36, 3'd4);
		// column groups past the frame edge
		render_cell(8'd100, 6'd40, 3'd5);
		render_cell(8'd100, 6'd63, 3'd6);
	endtask

	task automatic test_picture_cells();
		write_byte(13'd0, 8'hA5);
		write_byte(cell_attr_addr(8'd32, 6'd4), 8'h0A);
		render_cell(8'd32, 6'd4, 3'd7);
		write_byte(13'd8191, 8'hFF);
		write_byte(cell_pixel_addr(8'd223, 6'd35), 8'h0F);
		write_byte(cell_attr_addr(8'd223, 6'd35), 8'hC5);
		render_cell(8'd223, 6'd35, 3'd0);
		write_byte(cell_pixel_addr(8'd120, 6'd20), 8'hFF);
		write_byte(cell_attr_addr(8'd120, 6'd20), 8'h9C);
		render_cell(8'd120, 6'd20, 3'd0);
		write_byte(cell_pixel_addr(8'd120, 6'd20), 8'h00);
		render_cell(8'd120, 6'd20, 3'd0);
	endtask

	task automatic test_flash_blink();
		// sixteen frames set bit 4 of the blink counter
		repeat (16) end_frame();
		render_cell(8'd223, 6'd35, 3'd0);
		render_cell(8'd32, 6'd4, 3'd0);
		write_byte(cell_pixel_addr(8'd120, 6'd20), 8'h3C);
		render_cell(8'd120, 6'd20, 3'd0);
		repeat (16) end_frame();
		render_cell(8'd120, 6'd20, 3'd0);
	endtask

	task automatic test_unused_func();
		cmd_t c;
		c = random_cmd();
		c.func = FUNC_UNUSED;
		send_cmd(c);
		render_cell(8'd32, 6'd4, 3'd1);
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int stall);
		int         sent;
		int         pick;
		logic [7:0] ln;
		logic [5:0] col;
		cmd_t       c;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		sent = 0;
		while (sent < n) begin
			pick = int'($urandom_range(99));
			ln = 8'($urandom_range(PIC_BOTTOM - 1, PIC_TOP));
			col = 6'($urandom_range(PIC_RIGHT - 1, PIC_LEFT));
			if (pick < 45) begin
				write_byte(cell_pixel_addr(ln, col), 8'($urandom_range(255)));
				write_byte(cell_attr_addr(ln, col), 8'($urandom_range(255)));
				render_cell(ln, col, 3'($urandom_range(7)));
				sent += 3;
			end else if (pick < 55) begin
				render_cell(ln, col, 3'($urandom_range(7)));
				sent++;
			end else if (pick < 70) begin
				c = random_cmd();
				c.func = FUNC_RENDER;
				send_cmd(c);
				sent++;
			end else if (pick < 82) begin
				c = random_cmd();
				c.func = FUNC_WRITE;
				send_cmd(c);
				sent++;
			end else if (pick < 95) begin
				end_frame();
				sent++;
			end else begin
				c = random_cmd();
				c.func = FUNC_UNUSED;
				send_cmd(c);
			end
		end
		wait_for_pixels();
	endtask

	always @(posedge clk) begin
		pixel_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel transfer: rgba %h last %b", pixel_ch.rgba, pixel_ch.last);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_ch.rgba !== want.rgba) begin
					$error("rgba: expected %h, got %h", want.rgba, pixel_ch.rgba);
					mismatches++;
				end
				if (pixel_ch.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, pixel_ch.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_WRITE;
		cmd_ch.addr = '0;
		cmd_ch.data = '0;
		cmd_ch.line = '0;
		cmd_ch.column = '0;
		cmd_ch.border = '0;
		pixel_ch.ready = 1'b0;
		foreach (video_mem[i]) video_mem[i] = 8'h00;
		blink_ctr = 5'd0;
		mismatches = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_border_cells();
		test_picture_cells();
		test_flash_blink();
		test_unused_func();
		wait_for_pixels();
		test_random_traffic(88, 0, 0);
		test_random_traffic(88, 56, 0);
		test_random_traffic(88, 0, 56);
		test_random_traffic(88, 34, 34);

		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
